// ===== rtl/mexp_pkg.sv =====
// Shared types and constants for the modular exponentiation block.
// Used by mexp_ctrl, mexp_dp and modular_exponentiation; depends on nothing.
`default_nettype none

package mexp_pkg;

    // Width of every payload field and of the configuration word
    localparam int FIELD_W = 32;

    // Modulus after reset (1e9 + 7)
    localparam logic [FIELD_W-1:0] RESET_MODULUS = 32'd1000000007;

    // Operand selection for the shared modular multiplier
    typedef enum logic [1:0] {
        ENG_REDUCE = 2'd0,   // 1 * base: reduces the raw base
        ENG_SQUARE = 2'd1,   // acc * acc
        ENG_MULT   = 2'd2    // acc * base
    } t_eng_sel;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load;        // capture func and exponent of an accepted word
        logic     eng_start;   // start the modular multiplier
        t_eng_sel eng_sel;     // operands for that start
        logic     take_base;   // base <= multiplier result
        logic     exp_load;    // set up the exponent scan, acc <= 1
        logic     acc_zero;    // acc <= 0
        logic     acc_take;    // acc <= multiplier result
        logic     exp_shift;   // advance to the next exponent bit
        logic     out_load;    // move acc into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic eng_busy;    // multiplier still running
        logic mod_small;   // modulus below 2
        logic func;        // inverse requested
        logic base_zero;   // reduced base is zero
        logic acc_one;     // running value is 1
        logic exp_msb;     // exponent bit under scan
        logic bits_done;   // all exponent bits scanned
        logic out_free;    // output register can take a word this cycle
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/mexp_dp.sv =====
// Datapath of the modular exponentiation block: modulus register, operand
// registers, bit-serial modular multiplier and the output register.
// Depends on mexp_pkg.
`default_nettype none

module mexp_dp #(
    parameter int DW = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration write
    input  wire logic                       i_cfg_we,
    input  wire logic [DW-1:0]              i_cfg_modulus,
    // input word
    input  wire logic                       i_func,
    input  wire logic [DW-1:0]              i_base,
    input  wire logic [DW-1:0]              i_exponent,
    // output word
    input  wire logic                       i_out_stall,
    output logic                            o_out_valid,
    output logic [DW-1:0]                   o_result,
    // controller link
    input  wire mexp_pkg::t_dp_cmd          i_cmd,
    output mexp_pkg::t_dp_stat              o_stat
);
    import mexp_pkg::*;

    localparam int CW = $clog2(DW + 1);
    localparam int EW = DW + 2;

    logic [DW-1:0] r_modulus;
    logic          r_func;
    logic [DW-1:0] r_base;
    logic [DW-1:0] r_acc;
    logic [DW-1:0] r_exp;
    logic [CW-1:0] r_bits;
    logic [DW-1:0] r_result;
    logic          r_out_valid;

    logic [DW-1:0] r_eng_a;
    logic [DW-1:0] r_eng_b;
    logic [DW-1:0] r_rem;
    logic [CW-1:0] r_eng_cnt;
    logic          r_eng_busy;

    logic [EW-1:0] eng_t;
    logic [EW-1:0] eng_m1;
    logic [EW-1:0] eng_m2;
    logic [DW-1:0] n_rem;
    logic          out_free;

    // Hold the modulus; it is to be written only while idle, which the block does not enforce
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus <= RESET_MODULUS[DW-1:0];
        end else if (i_cfg_we) begin
            r_modulus <= i_cfg_modulus;
        end
    end

    // One multiplier bit: rem = (2 * rem + bit * a) mod m, with 2 * rem + a < 3m
    always_comb begin
        eng_m1 = EW'(r_modulus);
        eng_m2 = EW'({r_modulus, 1'b0});
        eng_t  = EW'({r_rem, 1'b0}) + (r_eng_b[DW-1] ? EW'(r_eng_a) : '0);
        if (eng_t >= eng_m2) begin
            n_rem = DW'(eng_t - eng_m2);
        end else if (eng_t >= eng_m1) begin
            n_rem = DW'(eng_t - eng_m1);
        end else begin
            n_rem = DW'(eng_t);
        end
    end

    // Modular multiplier: load operands on start, then one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng_busy <= 1'b0;
            r_eng_cnt  <= '0;
        end else if (i_cmd.eng_start) begin
            r_eng_busy <= 1'b1;
            r_eng_cnt  <= CW'(DW);
        end else if (r_eng_busy) begin
            r_eng_busy <= (r_eng_cnt != CW'(1));
            r_eng_cnt  <= r_eng_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eng_start) begin
            r_rem <= '0;
            case (i_cmd.eng_sel)
                ENG_REDUCE: begin
                    r_eng_a <= DW'(1);
                    r_eng_b <= i_base;
                end
                ENG_SQUARE: begin
                    r_eng_a <= r_acc;
                    r_eng_b <= r_acc;
                end
                default: begin
                    r_eng_a <= r_acc;
                    r_eng_b <= r_base;
                end
            endcase
        end else if (r_eng_busy) begin
            r_rem   <= n_rem;
            r_eng_b <= {r_eng_b[DW-2:0], 1'b0};
        end
    end

    // Capture the word, then keep base, acc and the exponent scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_exp  <= i_exponent;
        end else if (i_cmd.exp_load) begin
            if (r_func) begin
                r_exp <= r_modulus - DW'(2);
            end
        end else if (i_cmd.exp_shift) begin
            r_exp <= {r_exp[DW-2:0], 1'b0};
        end

        if (i_cmd.exp_load) begin
            r_bits <= CW'(DW);
        end else if (i_cmd.exp_shift) begin
            r_bits <= r_bits - CW'(1);
        end

        if (i_cmd.take_base) begin
            r_base <= r_rem;
        end

        if (i_cmd.exp_load) begin
            r_acc <= DW'(1);
        end else if (i_cmd.acc_zero) begin
            r_acc <= '0;
        end else if (i_cmd.acc_take) begin
            r_acc <= r_rem;
        end
    end

    // Output register: load a finished word, drop it once taken
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result <= r_acc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    // Status back to the controller
    always_comb begin
        o_stat.eng_busy  = r_eng_busy;
        o_stat.mod_small = (r_modulus[DW-1:1] == '0);
        o_stat.func      = r_func;
        o_stat.base_zero = (r_base == '0);
        o_stat.acc_one   = (r_acc == DW'(1));
        o_stat.exp_msb   = r_exp[DW-1];
        o_stat.bits_done = (r_bits == '0);
        o_stat.out_free  = out_free;
    end

    // Checks
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eng_start |-> !r_eng_busy)
        else $error("multiplier started while busy");

    a_busy_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eng_busy |-> (r_eng_cnt != '0))
        else $error("multiplier busy with no bits left");

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> out_free)
        else $error("output word overwritten while stalled");

endmodule

`default_nettype wire

// ===== rtl/mexp_ctrl.sv =====
// Controller of the modular exponentiation block: sequences base reduction,
// the square-and-multiply scan and the hand-off to the output register.
// Depends on mexp_pkg.
`default_nettype none

module mexp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire mexp_pkg::t_dp_stat   i_stat,
    output mexp_pkg::t_dp_cmd         o_cmd
);
    import mexp_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RED   = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_BIT   = 7'b0001000,
        S_SQR   = 7'b0010000,
        S_TEST  = 7'b0100000,
        S_MUL   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_done;
    logic   n_done;

    // r_done marks the wait for the output register once a result is ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_in_stall = (r_state != S_IDLE) || r_done;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        o_cmd   = '0;
        o_cmd.eng_sel = ENG_REDUCE;
        unique case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    if (i_stat.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_done         = 1'b0;
                    end
                end else if (i_in_valid) begin
                    o_cmd.load      = 1'b1;
                    o_cmd.eng_start = 1'b1;
                    o_cmd.eng_sel   = ENG_REDUCE;
                    n_state         = S_RED;
                end
            end
            S_RED: begin
                if (!i_stat.eng_busy) begin
                    o_cmd.take_base = 1'b1;
                    n_state         = S_CHECK;
                end
            end
            S_CHECK: begin
                // tiny modulus, or inverse of zero: the answer is zero
                if (i_stat.mod_small || (i_stat.func && i_stat.base_zero)) begin
                    o_cmd.acc_zero = 1'b1;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    o_cmd.exp_load = 1'b1;
                    n_state        = S_BIT;
                end
            end
            S_BIT: begin
                if (i_stat.bits_done) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (i_stat.acc_one) begin
                    // squaring 1 gives 1: go straight to the bit test
                    n_state = S_TEST;
                end else begin
                    o_cmd.eng_start = 1'b1;
                    o_cmd.eng_sel   = ENG_SQUARE;
                    n_state         = S_SQR;
                end
            end
            S_SQR: begin
                if (!i_stat.eng_busy) begin
                    o_cmd.acc_take = 1'b1;
                    n_state        = S_TEST;
                end
            end
            S_TEST: begin
                if (i_stat.exp_msb) begin
                    o_cmd.eng_start = 1'b1;
                    o_cmd.eng_sel   = ENG_MULT;
                    n_state         = S_MUL;
                end else begin
                    o_cmd.exp_shift = 1'b1;
                    n_state         = S_BIT;
                end
            end
            S_MUL: begin
                if (!i_stat.eng_busy) begin
                    o_cmd.acc_take  = 1'b1;
                    o_cmd.exp_shift = 1'b1;
                    n_state         = S_BIT;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_done  = 1'b0;
            end
        endcase
    end

    // Checks
    a_idle_engine_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_stat.eng_busy)
        else $error("multiplier running while controller idle");

endmodule

`default_nettype wire

// ===== rtl/modular_exponentiation.sv =====
// Modular exponentiation: result = base^exponent mod modulus (func 0), or the
// inverse base^(modulus-2) mod modulus by Fermat's rule (func 1, prime modulus).
// The base is first reduced mod modulus; a modulus below 2 gives 0, and the
// inverse of a zero base gives 0. All products run through one shared modular
// multiplier that consumes one multiplier bit per cycle, on operands of
// W = min(OPERAND_WIDTH, 32) bits. Each word takes a reduction pass, then
// the accept, checks and hand-off, and per exponent bit one square and one
// multiply when the bit is set, plus any wait for the output register; the
// square is skipped while the running value is 1, which always holds at the
// top bit. One word is worked on at a time; a finished word waits in the
// output register while the next is taken.
// The modulus register is written through the cfg port; the user must write
// it only while the block is idle, which the block does not enforce.
// Depends on mexp_pkg, mexp_ctrl and mexp_dp.
`default_nettype none

module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [mexp_pkg::FIELD_W-1:0]   i_cfg_modulus,
    // input words
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_func,
    input  wire logic [mexp_pkg::FIELD_W-1:0]   i_base,
    input  wire logic [mexp_pkg::FIELD_W-1:0]   i_exponent,
    // output words
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [mexp_pkg::FIELD_W-1:0]        o_result
);
    import mexp_pkg::*;

    localparam int DW = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;

    t_dp_cmd       cmd;
    t_dp_stat      stat;
    logic [DW-1:0] dp_result;

    assign o_cfg_ready = 1'b1;

    mexp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mexp_dp #(
        .DW (DW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_modulus (i_cfg_modulus[DW-1:0]),
        .i_func        (i_func),
        .i_base        (i_base[DW-1:0]),
        .i_exponent    (i_exponent[DW-1:0]),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_result      (dp_result),
        .i_cmd         (cmd),
        .o_stat        (stat)
    );

    assign o_result = FIELD_W'(dp_result);

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for modular_exponentiation: random and directed words, expected
// residues predicted in a scoreboard class, random idling on both channels.
// Depends on mexp_pkg and the modular_exponentiation RTL.
`timescale 1ns / 1ps

module testbench;

    import mexp_pkg::*;

    localparam int W = FIELD_W;

    // Function select codes on i_func
    localparam bit FUNC_POWER   = 1'b0;
    localparam bit FUNC_INVERSE = 1'b1;

    // Limit on the whole run, with ample room for stalls
    localparam int unsigned CYCLE_LIMIT  = 12_000_000;
    localparam int unsigned TAIL_CYCLES  = 2500;
    localparam int unsigned PHASE_WORDS  = 94;
    localparam int unsigned REPORT_LIMIT = 10;

    // Expected residues in arrival order, with the predictor's copy of the modulus
    class residue_book;
        bit [W-1:0]  modulus;
        bit [W-1:0]  pending[$];
        int unsigned error_count;

        function new();
            modulus     = RESET_MODULUS;
            error_count = 0;
        endfunction

        // b^e mod modulus by square-and-multiply, top exponent bit first; b < modulus
        function bit [W-1:0] raise(bit [W-1:0] b, bit [W-1:0] e);
            bit [63:0] acc;
            bit [63:0] m;
            acc = 64'd1;
            m   = modulus;
            for (int i = W - 1; i >= 0; i--) begin
                acc = (acc * acc) % m;
                if (e[i]) begin
                    acc = (acc * b) % m;
                end
            end
            return acc[W-1:0];
        endfunction

        // Predict the residue for an accepted word and queue it
        function void note_request(bit func, bit [W-1:0] base, bit [W-1:0] exponent);
            bit [W-1:0] m;
            bit [W-1:0] b;
            bit [W-1:0] want;
            m = modulus;
            if (m < 2) begin
                want = '0;
            end else begin
                b = base % m;
                if (func == FUNC_INVERSE) begin
                    want = (b == 0) ? '0 : raise(b, m - 2);
                end else begin
                    want = raise(b, exponent);
                end
            end
            pending.insert(pending.size(), want);
        endfunction

        // Compare an accepted result word with the oldest expectation
        function void check_result(logic [W-1:0] actual);
            bit [W-1:0] want;
            if (pending.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_LIMIT) begin
                    $display("%0t: result %0d arrived with nothing pending", $realtime, actual);
                end
            end else begin
                want = pending.pop_front();
                if (actual !== want) begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT) begin
                        $display("%0t: result mismatch: expected %0d, got %0d",
                                 $realtime, want, actual);
                    end
                end
            end
        endfunction
    endclass

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_valid   = 1'b0;
    logic         o_cfg_ready;
    logic [W-1:0] i_cfg_modulus = '0;
    logic         i_in_valid    = 1'b0;
    logic         o_in_stall;
    logic         i_func        = FUNC_POWER;
    logic [W-1:0] i_base        = '0;
    logic [W-1:0] i_exponent    = '0;
    logic         o_out_valid;
    logic         i_out_stall   = 1'b0;
    logic [W-1:0] o_result;

    residue_book  book = new();
    int unsigned  sender_gap_pct = 22;
    int unsigned  sink_stall_pct = 68;
    int unsigned  cycle_count    = 0;

    modular_exponentiation u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_modulus (i_cfg_modulus),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_base        (i_base),
        .i_exponent    (i_exponent),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result      (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Check each accepted result word, then pick the next stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            book.check_result(o_result);
        end
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Offer one word, idling first at random; return at the accepting edge
    task automatic send_word(bit func, bit [W-1:0] base, bit [W-1:0] exponent);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= func;
        i_base     <= base;
        i_exponent <= exponent;
        do @(posedge i_clk); while (o_in_stall);
        book.note_request(func, base, exponent);
    endtask

    // Hold off new words until every expected result has come
    task automatic drain();
        i_in_valid <= 1'b0;
        while (book.pending.size() != 0) @(posedge i_clk);
    endtask

    // Write the modulus register; call only while the block is idle
    task automatic write_modulus(bit [W-1:0] value);
        i_cfg_valid   <= 1'b1;
        i_cfg_modulus <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        book.modulus = value;
    endtask

    // Random word: mostly short exponents, inverses rarer for wide moduli
    task automatic send_random();
        bit          func;
        bit [W-1:0]  base;
        bit [W-1:0]  exponent;
        bit [W-1:0]  m;
        int unsigned w;
        m    = book.modulus;
        func = ($urandom_range(99) < ((m >= 32'h0100_0000) ? 10 : 35)) ? FUNC_INVERSE
                                                                       : FUNC_POWER;
        case ($urandom_range(9))
            0:       base = '0;
            1:       base = '1;
            2:       base = m - 1;
            3:       base = m;
            4:       base = 1;
            5, 6:    base = $urandom % m;
            default: base = $urandom;
        endcase
        case ($urandom_range(19))
            0:          exponent = '0;
            1:          exponent = 1;
            2:          exponent = '1;
            3, 4, 5, 6: exponent = $urandom;
            default: begin
                w        = $urandom_range(10);
                exponent = $urandom & ((32'd1 << w) - 1);
            end
        endcase
        send_word(func, base, exponent);
    endtask

    initial begin
        bit [W-1:0] phase_moduli[12];

        phase_moduli = '{32'd2, 32'd97, 32'd1000000007, 32'hFFFF_FFFF,
                         32'd3, 32'd65521, 32'hFFFF_FFFB, 32'd0,
                         32'd2147483647, 32'd0, 32'd5, 32'hFFFF_FFFB};
        phase_moduli[7] = $urandom_range(32'hFFFF_FFFF, 2);
        phase_moduli[9] = $urandom_range(32'h0000_FFFF, 2);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset modulus: zero exponent, zero base, wide bases,
        // base equal to or a multiple of the modulus, exponent ignored for inverses
        send_word(FUNC_POWER,   32'd0,          32'd0);
        send_word(FUNC_POWER,   32'd5,          32'd0);
        send_word(FUNC_POWER,   32'd0,          32'd5);
        send_word(FUNC_POWER,   32'hFFFF_FFFF,  32'd1);
        send_word(FUNC_POWER,   32'hFFFF_FFFF,  32'hFFFF_FFFF);
        send_word(FUNC_POWER,   32'd1000000007, 32'd3);
        send_word(FUNC_POWER,   32'd2,          32'd31);
        send_word(FUNC_POWER,   32'd2,          32'd32);
        send_word(FUNC_POWER,   32'd123456789,  32'h8000_0000);
        send_word(FUNC_INVERSE, 32'd0,          32'd7);
        send_word(FUNC_INVERSE, 32'd1,          32'd0);
        send_word(FUNC_INVERSE, 32'd2,          32'hFFFF_FFFF);
        send_word(FUNC_INVERSE, 32'hFFFF_FFFF,  32'd0);
        send_word(FUNC_INVERSE, 32'd4000000028, 32'd9);
        send_word(FUNC_INVERSE, 32'd1000000006, 32'd1);

        // Moduli below two give zero for everything
        drain();
        write_modulus(32'd1);
        send_word(FUNC_POWER,   32'd5,          32'd0);
        send_word(FUNC_INVERSE, 32'd7,          32'd3);
        send_word(FUNC_POWER,   32'hFFFF_FFFF,  32'hFFFF_FFFF);
        drain();
        write_modulus(32'd0);
        send_word(FUNC_POWER,   32'd5,          32'd0);
        send_word(FUNC_INVERSE, 32'd7,          32'd3);
        send_word(FUNC_POWER,   32'hFFFF_FFFF,  32'hFFFF_FFFF);

        // Random phases, one modulus each; swap idling, then run without idling
        for (int p = 0; p < 12; p++) begin
            if (p == 4) begin
                sender_gap_pct = 68;
                sink_stall_pct = 22;
            end else if (p == 8) begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            drain();
            write_modulus(phase_moduli[p]);
            repeat (PHASE_WORDS) send_random();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
